@@ src/gfi_pkg.sv @@
package gfi_pkg;

   localparam int KEY_W   = 32;
   localparam int VAL_W   = 32;
   localparam int DEV_W   = 31;
   localparam int COUNT_W = 32;
   localparam int CFG_W   = 4;
   localparam int TDATA_W = 128;

   // Sized for the largest grid the block supports (15 steps by 15 columns, the most the registers can set).
   localparam int ADDR_W    = 8;
   localparam int DA_W      = 4;
   localparam int DEN_W     = 6;
   localparam int NUM_W     = VAL_W + 6;
   localparam int DIV_LANES = 3;

   localparam int LANE_MEAN  = 0;
   localparam int LANE_DEV   = 1;
   localparam int LANE_COUNT = 2;

   typedef enum logic {
      CSR_STEPS   = 1'b0,
      CSR_COLUMNS = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      SEL_CUR,
      SEL_PREV,
      SEL_AFT,
      SEL_DIV
   } sel_type;

   typedef struct packed {
      logic [COUNT_W-1:0]      count;
      logic [DEV_W-1:0]        dev;
      logic signed [VAL_W-1:0] mean;
   } cell_type;

   typedef struct packed {
      logic              wr_in;
      logic              load_key;
      logic              rd_en;
      logic              rd_zero;
      logic              cap_cur;
      logic              cap_prev;
      logic              cap_aft;
      logic              prep;
      logic              start;
      logic              emit;
      logic              wr_res;
      logic              last;
      logic [ADDR_W-1:0] addr;
      logic [DA_W-1:0]   da;
      sel_type           sel;
   } dp_cmd_type;

   typedef struct packed {
      logic in_count_nz;
      logic key_zero;
      logic rd_cnt_zero;
      logic div_done;
   } dp_status_type;

endpackage

@@ src/gap_fill_interpolate_time_series.sv @@
// Gap filler for one row of time series statistics. Cells arrive in time-major
// order and are written to an on-chip store at one request per cycle while the
// block collects; cells beyond the grid are dropped. The request marked tlast
// closes the row. After a check of the row key the block walks the row and
// sends one result per cell: a cell with a nonzero count is read and sent; a
// gap adds one read of the previous step when it is not on the first step, a
// read of each later step searched for a neighbour, a decision and, when it
// lies between two neighbours, a set-up of the divider operands and a wait on
// the bit-serial divider. The single-port store and the divider set the pace.
// A row whose key (taken from its first cell) is zero gives no results, and a
// row without any nonzero count passes through unchanged. Requests are refused
// while a row is being computed; the last result of a row waits in the output
// register while the next row is taken in.
module gap_fill_interpolate_time_series
   import gfi_pkg::*;
#(
   parameter int MAX_STEPS   = 8,
   parameter int MAX_COLUMNS = 8
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic               csr_addr,
   input  logic [CFG_W-1:0]   csr_wdata,
   input  logic               req_tvalid,
   output logic               req_tready,
   // row_key, cell_mean, cell_dev, cell_count, then one zero bit
   input  logic [TDATA_W-1:0] req_tdata,
   input  logic               req_tlast,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   // out_key, out_mean, out_dev, out_count, then one zero bit
   output logic [TDATA_W-1:0] rsp_tdata,
   output logic               rsp_tlast
);

   dp_cmd_type    cmd;
   dp_status_type status;

   gfi_ctrl #(
      .MAX_STEPS   (MAX_STEPS),
      .MAX_COLUMNS (MAX_COLUMNS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_index_type'(csr_addr)),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   gfi_dpath #(
      .MAX_STEPS   (MAX_STEPS),
      .MAX_COLUMNS (MAX_COLUMNS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

   // A new result never overwrites one that has not been taken.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_tvalid || rsp_tready))
      else $error("result overwritten before it was taken");

   // Incoming cells and filled cells never compete for the store write port.
   a_one_writer: assert property (@(posedge clock) disable iff (reset)
      !(cmd.wr_in && cmd.wr_res))
      else $error("two writes to the cell store in one cycle");

   // The divider cannot finish in the cycle after it starts.
   a_div_latency: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> !status.div_done)
      else $error("divider finished too early");

   // No request is taken while a gap is being divided.
   a_no_req_in_divide: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> !req_tready)
      else $error("request accepted during a division");

endmodule

@@ src/gfi_div.sv @@
module gfi_div
   import gfi_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num [DIV_LANES],
   input  logic [DEN_W-1:0] den [DIV_LANES],
   output logic [NUM_W-1:0] quo [DIV_LANES],
   output logic             done
);

   localparam int ITER_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0]   work_ff [DIV_LANES];
   logic [DEN_W-2:0]   rem_ff  [DIV_LANES];
   logic [DEN_W-1:0]   den_ff  [DIV_LANES];
   logic [ITER_W-1:0]  iter_ff;
   logic               busy_ff;
   logic               done_ff;
   logic [DEN_W-1:0]   trial   [DIV_LANES];
   logic               fits    [DIV_LANES];

   // Restoring division, one quotient bit per lane per cycle; the quotient
   // shifts in at the bottom of the working word as the dividend leaves the top.
   always_comb begin
      for (int n = 0; n < DIV_LANES; n++) begin
         trial[n] = {rem_ff[n], work_ff[n][NUM_W-1]};
         fits[n]  = trial[n] >= den_ff[n];
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         for (int n = 0; n < DIV_LANES; n++) begin
            work_ff[n] <= num[n];
            rem_ff[n]  <= '0;
            den_ff[n]  <= den[n];
         end
      end else if (busy_ff) begin
         for (int n = 0; n < DIV_LANES; n++) begin
            work_ff[n] <= {work_ff[n][NUM_W-2:0], fits[n]};
            rem_ff[n]  <= fits[n] ? (DEN_W-1)'(trial[n] - den_ff[n]) : trial[n][DEN_W-2:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            iter_ff <= ITER_W'(NUM_W);
         end else if (busy_ff) begin
            iter_ff <= iter_ff - 1'b1;
            if (iter_ff == ITER_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign quo  = work_ff;
   assign done = done_ff;

endmodule

@@ src/gfi_ctrl.sv @@
module gfi_ctrl
   import gfi_pkg::*;
#(
   parameter int MAX_STEPS   = 8,
   parameter int MAX_COLUMNS = 8
)
(
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_we,
   input  csr_index_type csr_addr,
   input  logic [CFG_W-1:0] csr_wdata,
   input  logic          req_tvalid,
   input  logic          req_tlast,
   output logic          req_tready,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   localparam int STORE_DEPTH = MAX_STEPS * MAX_COLUMNS;
   localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
   localparam int STEP_W      = $clog2(MAX_STEPS + 1);
   localparam int COL_W       = $clog2(MAX_COLUMNS + 1);

   typedef enum logic [3:0] {
      S_COLLECT, S_CHECK, S_RD_CUR, S_GOT_CUR, S_GOT_PREV, S_SEARCH,
      S_GOT_AFT, S_DECIDE, S_PREP, S_START, S_DIVIDE, S_RESULT
   } state_type;

   state_type          state_ff, state_in;
   logic [CFG_W-1:0]   steps_cfg_ff, steps_cfg_in;
   logic [CFG_W-1:0]   cols_cfg_ff, cols_cfg_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]   have_ff, have_in;
   logic [CNT_W-1:0]   c_ff, c_in;
   logic [CNT_W:0]     aaddr_ff, aaddr_in;
   logic [STEP_W-1:0]  i_ff, i_in;
   logic [STEP_W-1:0]  k_ff, k_in;
   logic [COL_W-1:0]   j_ff, j_in;
   logic [DA_W-1:0]    da_ff, da_in;
   logic               any_ff, any_in;
   logic               hasb_ff, hasb_in;
   logic               hasa_ff, hasa_in;
   logic               valid_ff, valid_in;
   sel_type            sel_ff, sel_in;

   logic [STEP_W-1:0]  steps_c;
   logic [COL_W-1:0]   cols_c;
   logic [CNT_W-1:0]   total;
   logic               store_ok;
   logic               out_free;

   // Register values of zero act as one, values above the maximum as the maximum.
   always_comb begin
      if (steps_cfg_ff == '0) begin
         steps_c = STEP_W'(1);
      end else if (int'(steps_cfg_ff) > MAX_STEPS) begin
         steps_c = STEP_W'(MAX_STEPS);
      end else begin
         steps_c = STEP_W'(steps_cfg_ff);
      end
      if (cols_cfg_ff == '0) begin
         cols_c = COL_W'(1);
      end else if (int'(cols_cfg_ff) > MAX_COLUMNS) begin
         cols_c = COL_W'(MAX_COLUMNS);
      end else begin
         cols_c = COL_W'(cols_cfg_ff);
      end
   end

   assign total    = CNT_W'(steps_c * cols_c);
   assign store_ok = idx_ff < total;
   assign out_free = !valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      steps_cfg_in = steps_cfg_ff;
      cols_cfg_in  = cols_cfg_ff;
      idx_in       = idx_ff;
      have_in      = have_ff;
      c_in         = c_ff;
      aaddr_in     = aaddr_ff;
      i_in         = i_ff;
      k_in         = k_ff;
      j_in         = j_ff;
      da_in        = da_ff;
      any_in       = any_ff;
      hasb_in      = hasb_ff;
      hasa_in      = hasa_ff;
      sel_in       = sel_ff;
      valid_in     = valid_ff && !rsp_tready;
      cmd          = '0;
      cmd.sel      = sel_ff;
      cmd.da       = da_ff;
      req_tready   = (state_ff == S_COLLECT);

      if (csr_we) begin
         unique case (csr_addr)
            CSR_STEPS:   steps_cfg_in = csr_wdata;
            CSR_COLUMNS: cols_cfg_in  = csr_wdata;
         endcase
      end

      unique case (state_ff)
         S_COLLECT: begin
            if (req_tvalid) begin
               cmd.load_key = (idx_ff == '0);
               any_in = ((idx_ff == '0) ? 1'b0 : any_ff) || (store_ok && status.in_count_nz);
               if (store_ok) begin
                  cmd.wr_in = 1'b1;
                  cmd.addr  = ADDR_W'(idx_ff);
                  idx_in    = idx_ff + 1'b1;
               end
               if (req_tlast) begin
                  have_in  = store_ok ? idx_ff + 1'b1 : idx_ff;
                  idx_in   = '0;
                  state_in = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            c_in = '0;
            i_in = '0;
            j_in = '0;
            if (status.key_zero) begin
               any_in   = 1'b0;
               state_in = S_COLLECT;
            end else begin
               state_in = S_RD_CUR;
            end
         end
         S_RD_CUR: begin
            cmd.rd_en   = 1'b1;
            cmd.addr    = ADDR_W'(c_ff);
            cmd.rd_zero = c_ff >= have_ff;
            state_in    = S_GOT_CUR;
         end
         S_GOT_CUR: begin
            cmd.cap_cur = 1'b1;
            hasb_in     = 1'b0;
            hasa_in     = 1'b0;
            k_in        = i_ff + 1'b1;
            aaddr_in    = (CNT_W+1)'(c_ff) + (CNT_W+1)'(cols_c);
            if (!status.rd_cnt_zero || !any_ff) begin
               sel_in   = SEL_CUR;
               state_in = S_RESULT;
            end else if (i_ff != '0) begin
               cmd.rd_en = 1'b1;
               cmd.addr  = ADDR_W'(c_ff - CNT_W'(cols_c));
               state_in  = S_GOT_PREV;
            end else begin
               state_in = S_SEARCH;
            end
         end
         S_GOT_PREV: begin
            // The cell one step earlier is already filled, so it is the
            // neighbour before whenever the column holds any sample at all.
            cmd.cap_prev = 1'b1;
            hasb_in      = !status.rd_cnt_zero;
            state_in     = S_SEARCH;
         end
         S_SEARCH: begin
            if (k_ff < steps_c) begin
               cmd.rd_en   = 1'b1;
               cmd.addr    = ADDR_W'(aaddr_ff);
               cmd.rd_zero = aaddr_ff >= (CNT_W+1)'(have_ff);
               state_in    = S_GOT_AFT;
            end else begin
               state_in = S_DECIDE;
            end
         end
         S_GOT_AFT: begin
            cmd.cap_aft = 1'b1;
            if (!status.rd_cnt_zero) begin
               hasa_in  = 1'b1;
               da_in    = DA_W'(k_ff - i_ff);
               state_in = S_DECIDE;
            end else begin
               k_in     = k_ff + 1'b1;
               aaddr_in = aaddr_ff + (CNT_W+1)'(cols_c);
               state_in = S_SEARCH;
            end
         end
         S_DECIDE: begin
            if (hasb_ff && hasa_ff) begin
               state_in = S_PREP;
            end else begin
               sel_in   = hasb_ff ? SEL_PREV : (hasa_ff ? SEL_AFT : SEL_CUR);
               state_in = S_RESULT;
            end
         end
         S_PREP: begin
            cmd.prep = 1'b1;
            state_in = S_START;
         end
         S_START: begin
            cmd.start = 1'b1;
            sel_in    = SEL_DIV;
            state_in  = S_DIVIDE;
         end
         S_DIVIDE: begin
            if (status.div_done) begin
               state_in = S_RESULT;
            end
         end
         S_RESULT: begin
            if (out_free) begin
               cmd.emit   = 1'b1;
               cmd.wr_res = 1'b1;
               cmd.addr   = ADDR_W'(c_ff);
               cmd.last   = (c_ff + 1'b1) == total;
               valid_in   = 1'b1;
               if ((c_ff + 1'b1) == total) begin
                  any_in   = 1'b0;
                  state_in = S_COLLECT;
               end else begin
                  c_in     = c_ff + 1'b1;
                  state_in = S_RD_CUR;
                  if ((j_ff + 1'b1) == cols_c) begin
                     j_in = '0;
                     i_in = i_ff + 1'b1;
                  end else begin
                     j_in = j_ff + 1'b1;
                  end
               end
            end
         end
         default: state_in = S_COLLECT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_COLLECT;
         steps_cfg_ff <= CFG_W'(2);
         cols_cfg_ff  <= CFG_W'(1);
         idx_ff       <= '0;
         have_ff      <= '0;
         c_ff         <= '0;
         aaddr_ff     <= '0;
         i_ff         <= '0;
         k_ff         <= '0;
         j_ff         <= '0;
         da_ff        <= '0;
         any_ff       <= 1'b0;
         hasb_ff      <= 1'b0;
         hasa_ff      <= 1'b0;
         valid_ff     <= 1'b0;
         sel_ff       <= SEL_CUR;
      end else begin
         state_ff     <= state_in;
         steps_cfg_ff <= steps_cfg_in;
         cols_cfg_ff  <= cols_cfg_in;
         idx_ff       <= idx_in;
         have_ff      <= have_in;
         c_ff         <= c_in;
         aaddr_ff     <= aaddr_in;
         i_ff         <= i_in;
         k_ff         <= k_in;
         j_ff         <= j_in;
         da_ff        <= da_in;
         any_ff       <= any_in;
         hasb_ff      <= hasb_in;
         hasa_ff      <= hasa_in;
         valid_ff     <= valid_in;
         sel_ff       <= sel_in;
      end
   end

   assign rsp_tvalid = valid_ff;

endmodule

@@ src/gfi_dpath.sv @@
module gfi_dpath
   import gfi_pkg::*;
#(
   parameter int MAX_STEPS   = 8,
   parameter int MAX_COLUMNS = 8
)
(
   input  logic               clock,
   input  logic               reset,
   input  dp_cmd_type         cmd,
   output dp_status_type      status,
   input  logic [TDATA_W-1:0] req_tdata,
   output logic [TDATA_W-1:0] rsp_tdata,
   output logic               rsp_tlast
);

   localparam int STORE_DEPTH = MAX_STEPS * MAX_COLUMNS;
   localparam int AW          = $clog2(STORE_DEPTH);

   cell_type                store_mem [STORE_DEPTH];
   cell_type                rd_data_ff;
   logic                    rd_zero_ff;
   cell_type                rd_q;
   cell_type                cur_ff, prev_ff, aft_ff;
   cell_type                in_cell, res_cell, div_cell;
   cell_type                out_cell_ff;
   logic [KEY_W-1:0]        key_ff, out_key_ff;
   logic                    out_last_ff;
   logic                    neg_ff;
   logic [NUM_W-1:0]        num_ff [DIV_LANES];
   logic [DEN_W-1:0]        den_ff [DIV_LANES];
   logic [NUM_W-1:0]        quo    [DIV_LANES];
   logic                    div_done;
   logic signed [NUM_W-1:0] da_x, mean_num;
   logic [NUM_W-1:0]        dev_num, cnt_num, d_x;
   logic [VAL_W-1:0]        q_mean;

   assign in_cell.mean  = req_tdata[KEY_W +: VAL_W];
   assign in_cell.dev   = req_tdata[KEY_W+VAL_W +: DEV_W];
   assign in_cell.count = req_tdata[KEY_W+VAL_W+DEV_W +: COUNT_W];

   // Cells past the received part of a short row read as empty gaps.
   assign rd_q = rd_zero_ff ? cell_type'('0) : rd_data_ff;

   assign status.in_count_nz = in_cell.count != '0;
   assign status.key_zero    = key_ff == '0;
   assign status.rd_cnt_zero = rd_q.count == '0;
   assign status.div_done    = div_done;

   // The neighbour before sits one step back, so db is one and d is da + 1.
   always_comb begin
      da_x     = signed'(NUM_W'(cmd.da));
      d_x      = NUM_W'(cmd.da) + NUM_W'(1);
      mean_num = NUM_W'(prev_ff.mean) * da_x + NUM_W'(aft_ff.mean);
      dev_num  = NUM_W'(prev_ff.dev) * NUM_W'(cmd.da) + NUM_W'(aft_ff.dev);
      cnt_num  = ((NUM_W'(prev_ff.count) * NUM_W'(cmd.da) + NUM_W'(aft_ff.count)) << 1)
                 + d_x;
   end

   always_comb begin
      q_mean         = quo[LANE_MEAN][VAL_W-1:0];
      div_cell.mean  = neg_ff ? -q_mean : q_mean;
      div_cell.dev   = quo[LANE_DEV][DEV_W-1:0];
      div_cell.count = (quo[LANE_COUNT][NUM_W-1:COUNT_W] != '0) ? '1
                       : quo[LANE_COUNT][COUNT_W-1:0];
   end

   always_comb begin
      unique case (cmd.sel)
         SEL_CUR:  res_cell = cur_ff;
         SEL_PREV: res_cell = prev_ff;
         SEL_AFT:  res_cell = aft_ff;
         SEL_DIV:  res_cell = div_cell;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_in) begin
         store_mem[cmd.addr[AW-1:0]] <= in_cell;
      end else if (cmd.wr_res) begin
         store_mem[cmd.addr[AW-1:0]] <= res_cell;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= store_mem[cmd.addr[AW-1:0]];
         rd_zero_ff <= cmd.rd_zero;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_key) begin
         key_ff <= req_tdata[KEY_W-1:0];
      end
      if (cmd.cap_cur) begin
         cur_ff <= rd_q;
      end
      if (cmd.cap_prev) begin
         prev_ff <= rd_q;
      end
      if (cmd.cap_aft) begin
         aft_ff <= rd_q;
      end
      if (cmd.prep) begin
         neg_ff                 <= mean_num[NUM_W-1];
         num_ff[LANE_MEAN]      <= mean_num[NUM_W-1] ? NUM_W'(-mean_num) : NUM_W'(mean_num);
         num_ff[LANE_DEV]       <= dev_num;
         num_ff[LANE_COUNT]     <= cnt_num;
         den_ff[LANE_MEAN]      <= DEN_W'(d_x);
         den_ff[LANE_DEV]       <= DEN_W'(d_x);
         den_ff[LANE_COUNT]     <= DEN_W'(d_x << 1);
      end
      if (cmd.emit) begin
         out_cell_ff <= res_cell;
         out_key_ff  <= key_ff;
         out_last_ff <= cmd.last;
      end
   end

   gfi_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.start),
      .num   (num_ff),
      .den   (den_ff),
      .quo   (quo),
      .done  (div_done)
   );

   assign rsp_tdata = {1'b0, out_cell_ff.count, out_cell_ff.dev, out_cell_ff.mean, out_key_ff};
   assign rsp_tlast = out_last_ff;

endmodule

@@ tb/sv/gap_fill_interpolate_time_series_tb.sv @@
module gap_fill_interpolate_time_series_tb;
   import gfi_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 4000000;
   localparam int SETTLE_WAIT  = 4500;
   localparam int GRID_MAX     = 64;

   typedef enum {STIM_CELL, STIM_CSR} stim_kind_type;

   typedef struct {
      stim_kind_type      kind;
      logic [KEY_W-1:0]   key;
      logic [VAL_W-1:0]   mean;
      logic [DEV_W-1:0]   dev;
      logic [COUNT_W-1:0] count;
      bit                 last;
      bit                 typed;
      logic [VAL_W-1:0]   e_mean;
      logic [DEV_W-1:0]   e_dev;
      logic [COUNT_W-1:0] e_count;
   } stim_row_type;

   typedef struct {
      logic [KEY_W-1:0]   key;
      logic [VAL_W-1:0]   mean;
      logic [DEV_W-1:0]   dev;
      logic [COUNT_W-1:0] count;
      bit                 last;
   } filled_cell_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic csr_addr = 1'b0;
   logic [CFG_W-1:0] csr_wdata = '0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [TDATA_W-1:0] req_tdata = '0;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [TDATA_W-1:0] rsp_tdata;
   logic rsp_tlast;

   // Grid size seen by the filler, and the row being gathered.
   logic [CFG_W-1:0]   steps_reg = 4'd2;
   logic [CFG_W-1:0]   cols_reg = 4'd1;
   logic [VAL_W-1:0]   mean_row [GRID_MAX];
   logic [DEV_W-1:0]   dev_row [GRID_MAX];
   logic [COUNT_W-1:0] count_row [GRID_MAX];
   logic [KEY_W-1:0]   row_key = '0;
   int                 fill_idx = 0;
   bit                 seen_count = 0;

   filled_cell_type filled_q[$];
   filled_cell_type typed_q[$];
   stim_row_type    dir_tab[$];
   int              errors = 0;
   int              cycles = 0;
   bit              calm = 0;

   gap_fill_interpolate_time_series uut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
   );

   always #10 clock = ~clock;

   function automatic int grid_dim(input logic [CFG_W-1:0] v, input int lim);
      if (v == 0) return 1;
      if (v > lim) return lim;
      return int'(v);
   endfunction

   // Takes one accepted cell; on the closing cell fills the gaps of the row.
   task automatic take_cell(input stim_row_type r);
      int steps, cols, total, have, c, b, a, sb, sa, i, j, k;
      longint m [GRID_MAX];
      longint dv [GRID_MAX];
      longint unsigned cn [GRID_MAX];
      longint db, da, dd;
      longint unsigned num, q;
      bit fb, fa;
      filled_cell_type f;
      steps = grid_dim(steps_reg, 8);
      cols  = grid_dim(cols_reg, 8);
      total = steps * cols;
      if (fill_idx == 0) begin
         row_key = r.key;
         seen_count = 0;
         typed_q.delete();
      end
      if (r.typed) begin
         f = '{row_key, r.e_mean, r.e_dev, r.e_count, r.last};
         typed_q.push_back(f);
      end
      if (fill_idx < total) begin
         mean_row[fill_idx]  = r.mean;
         dev_row[fill_idx]   = r.dev;
         count_row[fill_idx] = r.count;
         if (r.count != 0) seen_count = 1;
         fill_idx++;
      end
      if (!r.last) return;
      have = fill_idx;
      fill_idx = 0;
      if (row_key == 0) return;
      if (r.typed) begin
         foreach (typed_q[n]) filled_q.push_back(typed_q[n]);
         return;
      end
      for (i = 0; i < total; i++) begin
         m[i]  = (i < have) ? longint'(signed'(mean_row[i])) : 0;
         dv[i] = (i < have) ? longint'(dev_row[i]) : 0;
         cn[i] = (i < have) ? longint'(count_row[i]) : 0;
      end
      if (seen_count) begin
         for (i = 0; i < steps; i++) begin
            for (j = 0; j < cols; j++) begin
               c = i * cols + j;
               if (cn[c] != 0) continue;
               fb = 0;
               fa = 0;
               b = 0;
               a = 0;
               for (k = i - 1; k >= 0; k--) begin
                  if (cn[k * cols + j] != 0) begin
                     fb = 1;
                     b = k;
                     break;
                  end
               end
               for (k = i + 1; k < steps; k++) begin
                  if (cn[k * cols + j] != 0) begin
                     fa = 1;
                     a = k;
                     break;
                  end
               end
               sb = b * cols + j;
               sa = a * cols + j;
               if (fb && !fa) begin
                  m[c] = m[sb]; dv[c] = dv[sb]; cn[c] = cn[sb];
               end else if (!fb && fa) begin
                  m[c] = m[sa]; dv[c] = dv[sa]; cn[c] = cn[sa];
               end else if (fb && fa) begin
                  db = i - b;
                  da = a - i;
                  dd = a - b;
                  m[c]  = (da * m[sb] + db * m[sa]) / dd;
                  dv[c] = (da * dv[sb] + db * dv[sa]) / dd;
                  num = longint'(da) * cn[sb] + longint'(db) * cn[sa];
                  // Rounded half up.
                  q = (2 * num + dd) / (2 * dd);
                  cn[c] = (q > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : q;
               end
            end
         end
      end
      for (i = 0; i < total; i++) begin
         f = '{row_key, m[i][VAL_W-1:0], dv[i][DEV_W-1:0], cn[i][COUNT_W-1:0],
               i == total - 1};
         filled_q.push_back(f);
      end
   endtask

   task automatic send_cell(input stim_row_type r);
      if (!calm && $urandom_range(99) < 38) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 38);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, r.count, r.dev, r.mean, r.key};
      req_tlast  <= r.last;
      do @(posedge clock); while (!req_tready);
      take_cell(r);
   endtask

   // Lets the block finish the row in hand, including rows that give nothing.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (filled_q.size() != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   task automatic write_grid(input logic [CFG_W-1:0] steps, input logic [CFG_W-1:0] cols);
      wait_idle();
      csr_we    <= 1'b1;
      csr_addr  <= CSR_STEPS;
      csr_wdata <= steps;
      @(posedge clock);
      csr_addr  <= CSR_COLUMNS;
      csr_wdata <= cols;
      @(posedge clock);
      csr_we    <= 1'b0;
      steps_reg = steps;
      cols_reg  = cols;
   endtask

   function automatic stim_row_type cell_item(input logic [31:0] key, input logic [31:0] mean,
                                              input logic [30:0] dev, input logic [31:0] count,
                                              input bit last);
      stim_row_type r;
      r = '{STIM_CELL, key, mean, dev, count, last, 0, '0, '0, '0};
      return r;
   endfunction

   function automatic stim_row_type fixed(input stim_row_type r, input logic [31:0] mean,
                                          input logic [30:0] dev, input logic [31:0] count);
      r.typed = 1;
      r.e_mean = mean;
      r.e_dev = dev;
      r.e_count = count;
      return r;
   endfunction

   function automatic stim_row_type grid(input logic [3:0] steps, input logic [3:0] cols);
      stim_row_type r;
      r = '{STIM_CSR, steps, cols, '0, '0, 0, 0, '0, '0, '0};
      return r;
   endfunction

   function automatic logic [31:0] rand_value();
      case ($urandom_range(3))
         0: return $urandom();
         1: return $urandom_range(2000) - 1000;
         2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return {16'($urandom_range(255) - 128), 16'h0};
      endcase
   endfunction

   function automatic logic [31:0] rand_count();
      case ($urandom_range(9))
         0, 1, 2, 3: return 0;
         4: return 32'hFFFF_FFFF;
         5, 6: return $urandom();
         default: return $urandom_range(20, 1);
      endcase
   endfunction

   always @(posedge clock) begin
      filled_cell_type e;
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
      rsp_tready <= calm || ($urandom_range(99) >= 38);
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (filled_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result %h last %b", rsp_tdata, rsp_tlast);
         end else begin
            e = filled_q.pop_front();
            if (rsp_tdata[31:0] !== e.key || rsp_tdata[63:32] !== e.mean ||
                rsp_tdata[94:64] !== e.dev || rsp_tdata[126:95] !== e.count ||
                rsp_tlast !== e.last) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch: expected key %h mean %h dev %h count %h last %b, got %h %h %h %h %b",
                           e.key, e.mean, e.dev, e.count, e.last, rsp_tdata[31:0],
                           rsp_tdata[63:32], rsp_tdata[94:64], rsp_tdata[126:95], rsp_tlast);
            end
         end
      end
   end

   initial begin
      stim_row_type r;
      int sent, ncells, total, p;
      bit empty_row;
      logic [3:0] ph_steps [6] = '{4'd3, 4'd0, 4'd4, 4'd1, 4'd2, 4'd15};
      logic [3:0] ph_cols [6]  = '{4'd2, 4'd0, 4'd3, 4'd8, 4'd12, 4'd3};

      // Two steps by one column after reset.
      r = cell_item(32'hFFFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 0);
      dir_tab.push_back(fixed(r, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 32'hFFFF_FFFF));
      r = cell_item(32'h1, 32'h8000_0000, 31'h0, 32'h1, 1);
      dir_tab.push_back(fixed(r, 32'h8000_0000, 31'h0, 32'h1));
      // A leading gap copies the only neighbour.
      r = cell_item(32'h5, 32'h0005_0000, 31'h3, 32'h0, 0);
      dir_tab.push_back(fixed(r, 32'hFFFD_0000, 31'h8, 32'h7));
      r = cell_item(32'h5, 32'hFFFD_0000, 31'h8, 32'h7, 1);
      dir_tab.push_back(fixed(r, 32'hFFFD_0000, 31'h8, 32'h7));
      // With no nonzero count the row passes through untouched.
      r = cell_item(32'h9, 32'h1234, 31'h5, 32'h0, 0);
      dir_tab.push_back(fixed(r, 32'h1234, 31'h5, 32'h0));
      r = cell_item(32'h9, 32'hFFFF_0000, 31'h2, 32'h0, 1);
      dir_tab.push_back(fixed(r, 32'hFFFF_0000, 31'h2, 32'h0));
      // Key zero on the first cell suppresses the row.
      r = cell_item(32'h0, 32'h77, 31'h1, 32'h3, 0);
      dir_tab.push_back(fixed(r, '0, '0, '0));
      r = cell_item(32'h7, 32'h66, 31'h1, 32'h0, 1);
      dir_tab.push_back(fixed(r, '0, '0, '0));
      dir_tab.push_back(cell_item(32'hB, 32'h100, 31'h4, 32'h9, 1));
      dir_tab.push_back(cell_item(32'hC, 32'h10, 31'h1, 32'h2, 0));
      dir_tab.push_back(cell_item(32'hC, 32'h20, 31'h2, 32'h0, 0));
      dir_tab.push_back(cell_item(32'hC, 32'h30, 31'h3, 32'h5, 1));
      dir_tab.push_back(cell_item(32'hD, 32'h40, 31'h4, 32'h4, 0));
      dir_tab.push_back(cell_item(32'hD, 32'h50, 31'h5, 32'h0, 1));
      dir_tab.push_back(grid(4'd3, 4'd1));
      dir_tab.push_back(cell_item(32'hE, 32'hFFFF_FFFF, 31'hA, 32'h1, 0));
      dir_tab.push_back(cell_item(32'hE, 32'h7, 31'h7, 32'h0, 0));
      dir_tab.push_back(cell_item(32'hE, 32'h0, 31'hB, 32'h2, 1));
      dir_tab.push_back(cell_item(32'hF, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 0));
      dir_tab.push_back(cell_item(32'hF, 32'h0, 31'h0, 32'h0, 0));
      dir_tab.push_back(cell_item(32'hF, 32'h8000_0000, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 1));
      dir_tab.push_back(grid(4'd0, 4'd0));
      dir_tab.push_back(cell_item(32'h10, 32'h5, 31'h5, 32'h0, 1));
      dir_tab.push_back(grid(4'd15, 4'd15));
      dir_tab.push_back(cell_item(32'h11, 32'hFFFF_8000, 31'h9, 32'h3, 1));
      dir_tab.push_back(grid(4'd4, 4'd2));
      for (int n = 0; n < 8; n++)
         dir_tab.push_back(cell_item(32'h12, n * 32'h1_0000, 31'(n),
                                     (n % 2 == 0 && n != 2) ? n + 1 : 0, n == 7));

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_tab[n]) begin
         if (dir_tab[n].kind == STIM_CSR) write_grid(dir_tab[n].key[3:0], dir_tab[n].mean[3:0]);
         else send_cell(dir_tab[n]);
      end

      // Random rows, grouped by grid setting; the last setting saturates the step count.
      sent = 0;
      for (p = 0; p < 6; p++) begin
         write_grid(ph_steps[p], ph_cols[p]);
         total = grid_dim(steps_reg, 8) * grid_dim(cols_reg, 8);
         for (int rows = 0; rows < ((total > 8) ? 1 : 2); rows++) begin
            calm = (sent >= 30 && sent < 70);
            ncells = total;
            case ($urandom_range(9))
               0: ncells = $urandom_range(total, 1);
               1: ncells = total + $urandom_range(3, 1);
               default: ;
            endcase
            empty_row = ($urandom_range(9) == 0);
            for (int n = 0; n < ncells; n++) begin
               r = cell_item((n == 0 && $urandom_range(11) == 0) ? 32'h0 : $urandom(),
                             rand_value(), 31'($urandom()), empty_row ? 32'h0 : rand_count(),
                             n == ncells - 1);
               send_cell(r);
               sent++;
            end
         end
      end
      calm = 0;
      wait_idle();
      if (errors == 0 && filled_q.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

@@ files.f @@
src/gfi_pkg.sv
src/gfi_div.sv
src/gfi_ctrl.sv
src/gfi_dpath.sv
src/gap_fill_interpolate_time_series.sv
tb/sv/gap_fill_interpolate_time_series_tb.sv
